>>> src/assert_macros.svh
// Assertion macros shared by the curve point unit modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHC_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication, disabled during reset
`define CHC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

>>> src/chc_pkg.sv
// Types and constants of the cubic Hermite curve point unit.
// No dependencies; imported by every module of the block.
package chc_pkg;

   // Field widths
   localparam int COORD_BITS    = 16;
   localparam int STEP_BITS     = 16;
   // Coefficients need four more bits than a coordinate (|B| < 6 * 2^16)
   localparam int COEF_BITS     = COORD_BITS + 4;

   // Register port
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-3:0] REG_NUM_STEPS = '0;
   localparam logic [STEP_BITS-1:0] NUM_STEPS_RESET = 16'd2000;

   // Coefficient queue between front and back
   localparam int QUEUE_DEPTH   = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COEF_BITS-1:0]  coef_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct packed {
      coord_type             start_x;
      coord_type             start_y;
      coord_type             start_handle_x;
      coord_type             start_handle_y;
      coord_type             end_x;
      coord_type             end_y;
      coord_type             end_handle_x;
      coord_type             end_handle_y;
      logic [STEP_BITS-1:0]  step_index;
   } req_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      logic      clipped;
   } rsp_type;

   // Cubic coefficients of one axis: a*u^3 + b*u^2 + c*u + d
   typedef struct packed {
      coef_type  a;
      coef_type  b;
      coef_type  c;
      coord_type d;
   } axis_coef_type;

   typedef struct packed {
      axis_coef_type x;
      axis_coef_type y;
   } curve_coef_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> src/chc_fifo.sv
// Short queue of coefficient/parameter items between front and back.
// Depends on chc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module chc_fifo
   import chc_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(QUEUE_DEPTH - 1);

   logic [WIDTH-1:0]    slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push;

   assign status.full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign push         = push_valid && !status.full;
   assign pop_data     = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CHC_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `CHC_ASSERT_IMPL(a_no_underflow, clock, reset, pop, count_ff != '0)
   `CHC_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(QUEUE_DEPTH))

endmodule

>>> src/chc_front.sv
// Front end: takes items, forms the cubic coefficients and the parameter u
// through a pipelined restoring divider. Depends on chc_pkg.
module chc_front
   import chc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_item,
   input  logic [STEP_BITS-1:0] num_steps,
   input  queue_status_type     queue_status,
   output logic                 push_valid,
   output curve_coef_type       push_coef,
   output logic [FRAC_BITS:0]   push_u
);

   // one quotient bit per stage, one extra bit for rounding
   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int UW        = FRAC_BITS + 1;
   localparam logic [UW-1:0] U_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic                 v_ff     [DIV_STEPS+1];
   logic                 v_in     [DIV_STEPS+1];
   logic [STEP_BITS-1:0] rem_ff   [DIV_STEPS+1];
   logic [STEP_BITS-1:0] rem_in   [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] quo_ff   [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] quo_in   [DIV_STEPS+1];
   logic                 clamp_ff [DIV_STEPS+1];
   logic                 clamp_in [DIV_STEPS+1];
   curve_coef_type       coef_ff  [DIV_STEPS+1];
   curve_coef_type       coef_in  [DIV_STEPS+1];
   logic [STEP_BITS:0]   diff     [DIV_STEPS];

   logic                 stage_en;
   logic [STEP_BITS-1:0] n_eff;
   logic                 clamp0;
   logic [DIV_STEPS:0]   q_plus;

   function automatic axis_coef_type axis_coefs(coord_type p0, coord_type h0,
                                                coord_type p1, coord_type h1);
      axis_coef_type r;
      coef_type      p0e, p1e, t0, t1, dp;
      p0e  = coef_type'(p0);
      p1e  = coef_type'(p1);
      t0   = coef_type'(h0) - p0e;
      t1   = coef_type'(h1) - p1e;
      dp   = p1e - p0e;
      r.a  = t0 + t1 - (dp <<< 1);
      r.b  = dp + (dp <<< 1) - (t0 <<< 1) - t1;
      r.c  = t0;
      r.d  = p0;
      return r;
   endfunction

   // whole front moves unless its last item cannot enter the queue
   assign stage_en  = !(v_ff[DIV_STEPS] && queue_status.full);
   assign req_stall = !stage_en;

   // a zero division count acts as one; indices at or past it give u = 1
   assign n_eff  = (num_steps == '0) ? STEP_BITS'(1) : num_steps;
   assign clamp0 = (req_item.step_index >= n_eff);

   // stage entry and one divider step per stage
   always_comb begin
      v_in[0]     = req_valid;
      rem_in[0]   = clamp0 ? '0 : req_item.step_index;
      quo_in[0]   = '0;
      clamp_in[0] = clamp0;
      coef_in[0].x = axis_coefs(req_item.start_x, req_item.start_handle_x,
                                req_item.end_x, req_item.end_handle_x);
      coef_in[0].y = axis_coefs(req_item.start_y, req_item.start_handle_y,
                                req_item.end_y, req_item.end_handle_y);
      for (int k = 1; k <= DIV_STEPS; k++) begin
         diff[k-1] = {rem_ff[k-1], 1'b0} - {1'b0, n_eff};
         if (diff[k-1][STEP_BITS]) begin
            rem_in[k] = {rem_ff[k-1][STEP_BITS-2:0], 1'b0};
            quo_in[k] = {quo_ff[k-1][DIV_STEPS-2:0], 1'b0};
         end else begin
            rem_in[k] = diff[k-1][STEP_BITS-1:0];
            quo_in[k] = {quo_ff[k-1][DIV_STEPS-2:0], 1'b1};
         end
         v_in[k]     = v_ff[k-1];
         clamp_in[k] = clamp_ff[k-1];
         coef_in[k]  = coef_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (stage_en) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            v_ff[k] <= v_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            rem_ff[k]   <= rem_in[k];
            quo_ff[k]   <= quo_in[k];
            clamp_ff[k] <= clamp_in[k];
            coef_ff[k]  <= coef_in[k];
         end
      end
   end

   // quotient carries one extra fraction bit: add one half and drop it
   assign q_plus     = {1'b0, quo_ff[DIV_STEPS]} + 1'b1;
   assign push_u     = clamp_ff[DIV_STEPS] ? U_ONE : q_plus[DIV_STEPS:1];
   assign push_valid = v_ff[DIV_STEPS];
   assign push_coef  = coef_ff[DIV_STEPS];

endmodule

>>> src/chc_back.sv
// Back end: powers of u, products, sum, rounding and saturation, and the
// result register. Depends on chc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module chc_back
   import chc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  queue_status_type   queue_status,
   output logic               pop,
   input  curve_coef_type     pop_coef,
   input  logic [FRAC_BITS:0] pop_u,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_item
);

   localparam int UW = FRAC_BITS + 1;
   localparam int PW = COEF_BITS + UW + 1;
   localparam int SW = PW + 3;
   localparam int RW = SW - FRAC_BITS;
   localparam logic [UW-1:0] U_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [SW-1:0] ROUND_HALF =
      {{(SW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic signed [RW-1:0] POS_LIMIT =
      {{(RW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [RW-1:0] NEG_LIMIT = ~POS_LIMIT;

   logic                  stage_en;
   logic                  v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;

   // stage 1: u and u^2
   logic [UW-1:0]         u1_ff, sq1_ff;
   curve_coef_type        coef1_ff;
   logic [2*UW-1:0]       sq_full;
   // stage 2: u, u^2, u^3
   logic [UW-1:0]         u2_ff, sq2_ff, cube2_ff;
   curve_coef_type        coef2_ff;
   logic [2*UW-1:0]       cube_full;
   // stage 3: products per axis (0 = x, 1 = y)
   axis_coef_type         ac        [2];
   logic signed [PW-1:0]  prod_a    [2];
   logic signed [PW-1:0]  prod_b    [2];
   logic signed [PW-1:0]  prod_c    [2];
   logic signed [PW-1:0]  prod_a_ff [2];
   logic signed [PW-1:0]  prod_b_ff [2];
   logic signed [PW-1:0]  prod_c_ff [2];
   coord_type             d3_ff     [2];
   // stage 4: partial sums
   logic signed [SW-1:0]  d_shift   [2];
   logic signed [SW-1:0]  s1_ff     [2];
   logic signed [SW-1:0]  s2_ff     [2];
   // stage 5: full sum
   logic signed [SW-1:0]  sum_ff    [2];
   // result register
   logic signed [RW-1:0]  rnd       [2];
   coord_type             pt        [2];
   logic                  clip      [2];
   rsp_type               rsp_item_ff, rsp_item_in;
   logic                  clip_at_bound;

   // the whole back freezes only while a result waits on the receiver
   assign stage_en = !(rsp_valid_ff && rsp_stall);
   assign pop      = stage_en && !queue_status.empty;

   assign sq_full   = pop_u * pop_u;
   assign cube_full = sq1_ff * u1_ff;

   // products and rounding, per axis
   always_comb begin
      ac[0] = coef2_ff.x;
      ac[1] = coef2_ff.y;
      for (int i = 0; i < 2; i++) begin
         prod_a[i]  = PW'(ac[i].a) * PW'($signed({1'b0, cube2_ff}));
         prod_b[i]  = PW'(ac[i].b) * PW'($signed({1'b0, sq2_ff}));
         prod_c[i]  = PW'(ac[i].c) * PW'($signed({1'b0, u2_ff}));
         d_shift[i] = {{(SW-COORD_BITS-FRAC_BITS){d3_ff[i][COORD_BITS-1]}},
                       d3_ff[i], {FRAC_BITS{1'b0}}};
         // floor of sum / 2^FRAC_BITS, rounding offset already added
         rnd[i] = sum_ff[i][SW-1:FRAC_BITS];
         if (rnd[i] > POS_LIMIT) begin
            pt[i]   = COORD_MAX;
            clip[i] = 1'b1;
         end else if (rnd[i] < NEG_LIMIT) begin
            pt[i]   = COORD_MIN;
            clip[i] = 1'b1;
         end else begin
            pt[i]   = rnd[i][COORD_BITS-1:0];
            clip[i] = 1'b0;
         end
      end
      rsp_item_in.point_x = pt[0];
      rsp_item_in.point_y = pt[1];
      rsp_item_in.clipped = clip[0] | clip[1];
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (stage_en) begin
         v1_ff        <= !queue_status.empty;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (stage_en) begin
         u1_ff    <= pop_u;
         sq1_ff   <= sq_full[FRAC_BITS +: UW];
         coef1_ff <= pop_coef;
         u2_ff    <= u1_ff;
         sq2_ff   <= sq1_ff;
         cube2_ff <= cube_full[FRAC_BITS +: UW];
         coef2_ff <= coef1_ff;
         for (int i = 0; i < 2; i++) begin
            prod_a_ff[i] <= prod_a[i];
            prod_b_ff[i] <= prod_b[i];
            prod_c_ff[i] <= prod_c[i];
            d3_ff[i]     <= ac[i].d;
            s1_ff[i]     <= SW'(prod_a_ff[i]) + SW'(prod_b_ff[i]);
            s2_ff[i]     <= SW'(prod_c_ff[i]) + d_shift[i] + ROUND_HALF;
            sum_ff[i]    <= s1_ff[i] + s2_ff[i];
         end
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // a clipped point has at least one coordinate at a range bound
   assign clip_at_bound = rsp_item_ff.point_x == COORD_MAX || rsp_item_ff.point_x == COORD_MIN
                       || rsp_item_ff.point_y == COORD_MAX || rsp_item_ff.point_y == COORD_MIN;

   `CHC_ASSERT_IMPL(a_u_range, clock, reset, v1_ff, u1_ff <= U_ONE)
   `CHC_ASSERT_IMPL(a_square_le_u, clock, reset, v2_ff, sq2_ff <= u2_ff)
   `CHC_ASSERT_IMPL(a_cube_le_square, clock, reset, v2_ff, cube2_ff <= sq2_ff)
   `CHC_ASSERT_IMPL(a_clip_saturates, clock, reset, rsp_valid && rsp_item.clipped, clip_at_bound)

endmodule

>>> src/cubic_hermite_curve_point_unit.sv
// Top level of the cubic Hermite curve point unit: register port, front end,
// coefficient queue and back end. Depends on chc_pkg, chc_front, chc_fifo, chc_back.
//
// Usage:
//   req channel (req_valid / req_stall / req_item) takes one curve segment and a
//   step index per item; rsp channel (rsp_valid / rsp_stall / rsp_item) returns
//   one point per item, in order, with the clipped flag.
//   num_steps sits at byte address 0 of the csr port; change it only while the
//   unit is empty.
// Throughput: one item per cycle while no stall holds the pipeline (see Stall).
//   Path: the divider that forms u, one quotient bit per stage (FRAC_BITS + 1
//   stages), then the coefficient queue, then six stages of powers, products,
//   sums and the result register.
// Reset: all pipeline and queue contents are dropped, num_steps returns to 2000.
// Stall: a stalled result holds the back end; the four-entry coefficient queue
//   keeps taking front-end items until it fills, then req_stall rises.
module cubic_hermite_curve_point_unit
   import chc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_item,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int QW = $bits(curve_coef_type) + FRAC_BITS + 1;

   logic [STEP_BITS-1:0]       num_steps_ff, num_steps_in;
   logic                       csr_write;
   logic [CSR_ADDR_BITS-3:0]   csr_word;
   logic                       push_valid;
   curve_coef_type             push_coef, pop_coef;
   logic [FRAC_BITS:0]         push_u, pop_u;
   logic [QW-1:0]              pop_data;
   logic                       pop;
   queue_status_type           queue_status;

   // register port
   assign csr_pready = 1'b1;
   assign csr_word   = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_word == REG_NUM_STEPS)
                     ? {{(CSR_DATA_BITS-STEP_BITS){1'b0}}, num_steps_ff} : '0;

   always_comb begin
      num_steps_in = num_steps_ff;
      if (csr_write && csr_word == REG_NUM_STEPS) begin
         num_steps_in = csr_pwdata[STEP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_steps_ff <= NUM_STEPS_RESET;
      end else begin
         num_steps_ff <= num_steps_in;
      end
   end

   chc_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .num_steps    (num_steps_ff),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_coef    (push_coef),
      .push_u       (push_u)
   );

   chc_fifo #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_coef, push_u}),
      .pop        (pop),
      .pop_data   (pop_data),
      .status     (queue_status)
   );

   assign pop_coef = pop_data[QW-1:FRAC_BITS+1];
   assign pop_u    = pop_data[FRAC_BITS:0];

   chc_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop          (pop),
      .pop_coef     (pop_coef),
      .pop_u        (pop_u),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_item     (rsp_item)
   );

endmodule
